// ----- hw/rtl/round_robin_thread_scheduler_assert.svh -----
// ---------------------------------------------------------------------------
// round robin thread scheduler assertion macros
// concurrent check helpers used by the scheduler rtl
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rrts_pkg.sv -----
// ---------------------------------------------------------------------------
// rrts_pkg
// types, codes and helpers of the round robin thread scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   localparam int MAX_THREADS_DEF = 16;

   localparam int ACT_W    = 3;
   localparam int TOKEN_W  = 64;
   localparam int DUR_W    = 64;
   localparam int HANDLE_W = 5;
   localparam int STAT_W   = 3;
   localparam int COUNT_W  = 5;
   localparam int TICK_W   = 64;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 80;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_SPAWN, ACT_DISPATCH, ACT_YIELD, ACT_SLEEP,
      ACT_WAIT, ACT_SIGNAL, ACT_JOIN, ACT_FINISH
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      RSP_OK, RSP_REFUSED, RSP_TICK, RSP_ALL_DONE, RSP_DEADLOCK, RSP_FULL
   } rsp_status_type;

   typedef enum logic [2:0] {
      SLOT_UNUSED, SLOT_READY, SLOT_RUNNING, SLOT_SLEEP,
      SLOT_WAIT, SLOT_JOIN, SLOT_DONE
   } slot_state_type;

   typedef struct packed {
      logic [TICK_W-1:0]   deadline;
      logic [TOKEN_W-1:0]  key;
      logic [HANDLE_W-1:0] join_on;
      logic                expired;
      slot_state_type      status;
   } slot_type;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_DECODE, FSM_CUR_RD, FSM_CUR_WR, FSM_JT_RD, FSM_JT_CHK,
      FSM_SIG_RD, FSM_SIG_EV, FSM_DA_RD, FSM_DA_EV, FSM_DB_RD, FSM_DB_EV,
      FSM_PICK, FSM_SEL_RD, FSM_SEL_WR, FSM_RESP
   } fsm_state_type;

   function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                 input logic [TICK_W-1:0] b);
      logic [TICK_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rrts_ram.sv -----
// ---------------------------------------------------------------------------
// rrts_ram
// simple dual port ram, one write and one registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/round_robin_thread_scheduler.sv -----
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler
// thread slot bookkeeping with round robin dispatch and virtual time
// ---------------------------------------------------------------------------
// Each req item carries one action (spawn, dispatch, yield, sleep, wait,
// signal, join, finish) and yields exactly one rsp item. All slot records
// live in one ram with a registered read; only threads that were spawned
// are ever read, so the ram needs no clearing after reset. The ram is read
// one slot at a time, so the work is set by slot scans: signal scans the
// slots in order, and dispatch makes two full passes over the ram (a
// finished-thread survey, then a wake and unblock pass that is skipped when
// every thread has finished) and then a round robin search that tries slots
// in turn from the round robin position. A new req item is taken once the
// previous one has its result in the output register, even if rsp is
// stalled.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req item
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // wait_token[63:0], wake_all[64], duration_ticks[128:65],
   // target_handle[133:129], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action[2:0]
   input  wire logic [ACT_W-1:0]      req_tuser,
   // rsp item
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // handle[4:0], woken_count[9:5], timed_out[10], now_tick[74:11], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status[2:0]
   output logic [STAT_W-1:0]          rsp_tuser
);

`include "round_robin_thread_scheduler_assert.svh"

   localparam int IW    = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
   localparam logic [CNT_W-1:0] CNT_ONE = 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_THREADS);
   localparam logic [CMP_W-1:0] CMP_ONE = 1;

   // control
   fsm_state_type    state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;     // slot under scan
   logic [IW-1:0]    k_ff, k_in;         // round robin tries
   logic [CNT_W-1:0] created_ff, created_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [IW-1:0]    rr_ff, rr_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [MAX_THREADS-1:0] done_mask_ff, done_mask_in;
   logic [MAX_THREADS-1:0] ready_mask_ff, ready_mask_in;
   logic             every_done_ff, every_done_in;
   logic             timed_ff, timed_in;
   logic             blocked_ff, blocked_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // latched item and result under build
   action_type           action_ff, action_in;
   logic [TOKEN_W-1:0]   token_ff, token_in;
   logic                 all_ff, all_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [HANDLE_W-1:0]  tgt_ff, tgt_in;
   rsp_status_type       res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]  res_handle_ff, res_handle_in;
   logic [CNT_W-1:0]     woken_ff, woken_in;
   logic                 res_timed_ff, res_timed_in;

   // output register
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ram port
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   slot_type      ram_wdata, rec, upd;
   logic [$bits(slot_type)-1:0] ram_rdata;

   // helpers
   logic          have;
   logic [IW-1:0] ci;
   logic          idx_last;
   logic [CNT_W-1:0] idx_p1;
   logic [CMP_W-1:0] tgt_ext, cur_ext, n_ext, tgt_m1, jt_ext, jt_m1;
   logic          jt_free;

   rrts_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (MAX_THREADS)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rec      = slot_type'(ram_rdata);
   assign have     = (cur_ff != '0) && (cur_ff <= created_ff);
   assign ci       = IW'(cur_ff - CNT_ONE);
   assign idx_p1   = CNT_W'(idx_ff) + CNT_ONE;
   assign idx_last = (idx_p1 == created_ff);
   assign tgt_ext  = CMP_W'(tgt_ff);
   assign cur_ext  = CMP_W'(cur_ff);
   assign n_ext    = CMP_W'(created_ff);
   assign tgt_m1   = tgt_ext - CMP_ONE;
   assign jt_ext   = CMP_W'(rec.join_on);
   assign jt_m1    = jt_ext - CMP_ONE;
   // join target gone, out of range, or finished
   assign jt_free  = (jt_ext == '0) || (jt_ext > n_ext) || done_mask_ff[jt_m1[IW-1:0]];

   assign req_tready = (state_ff == FSM_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         created_ff   <= '0;
         cur_ff       <= '0;
         rr_ff        <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         created_ff   <= created_in;
         cur_ff       <= cur_in;
         rr_ff        <= rr_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      done_mask_ff  <= done_mask_in;
      ready_mask_ff <= ready_mask_in;
      every_done_ff <= every_done_in;
      timed_ff      <= timed_in;
      blocked_ff    <= blocked_in;
      action_ff     <= action_in;
      token_ff      <= token_in;
      all_ff        <= all_in;
      dur_ff        <= dur_in;
      tgt_ff        <= tgt_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      woken_ff      <= woken_in;
      res_timed_ff  <= res_timed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      created_in    = created_ff;
      cur_in        = cur_ff;
      rr_in         = rr_ff;
      tick_in       = tick_ff;
      done_mask_in  = done_mask_ff;
      ready_mask_in = ready_mask_ff;
      every_done_in = every_done_ff;
      timed_in      = timed_ff;
      blocked_in    = blocked_ff;
      rsp_valid_in  = rsp_valid_ff;
      action_in     = action_ff;
      token_in      = token_ff;
      all_in        = all_ff;
      dur_in        = dur_ff;
      tgt_in        = tgt_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      woken_in      = woken_ff;
      res_timed_in  = res_timed_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_raddr     = idx_ff;
      ram_wdata     = rec;
      upd           = rec;

      // output register drains on its own side
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) begin
               action_in     = action_type'(req_tuser);
               token_in      = req_tdata[63:0];
               all_in        = req_tdata[64];
               dur_in        = req_tdata[128:65];
               tgt_in        = req_tdata[133:129];
               res_status_in = RSP_OK;
               res_handle_in = '0;
               woken_in      = '0;
               res_timed_in  = 1'b0;
               idx_in        = '0;
               state_in      = FSM_DECODE;
            end
         end

         FSM_DECODE: begin
            state_in = FSM_RESP;
            unique case (action_ff)
               ACT_SPAWN: begin
                  if (created_ff >= CNT_MAX) begin
                     res_status_in = RSP_FULL;
                  end else begin
                     ram_we            = 1'b1;
                     ram_waddr         = created_ff[IW-1:0];
                     ram_wdata         = '0;
                     ram_wdata.status  = SLOT_READY;
                     created_in        = created_ff + CNT_ONE;
                     res_handle_in     = HANDLE_W'(created_ff + CNT_ONE);
                  end
               end
               ACT_DISPATCH: begin
                  if (have) begin
                     res_status_in = RSP_REFUSED;
                  end else if (created_ff == '0) begin
                     res_status_in = RSP_ALL_DONE;
                  end else begin
                     every_done_in = 1'b1;
                     state_in      = FSM_DA_RD;
                  end
               end
               ACT_SIGNAL: begin
                  if (created_ff != '0) begin
                     state_in = FSM_SIG_RD;
                  end
               end
               ACT_JOIN: begin
                  if (!have || tgt_ext == cur_ext || tgt_ext == '0 || tgt_ext > n_ext) begin
                     res_status_in = RSP_REFUSED;
                  end else begin
                     state_in = FSM_JT_RD;
                  end
               end
               default: begin
                  // yield, sleep, wait, finish act on the running thread
                  if (!have) begin
                     res_status_in = RSP_REFUSED;
                  end else begin
                     state_in = FSM_CUR_RD;
                  end
               end
            endcase
         end

         FSM_JT_RD: begin
            ram_raddr = tgt_m1[IW-1:0];
            state_in  = FSM_JT_CHK;
         end

         FSM_JT_CHK: begin
            // joining a finished thread leaves the caller running
            state_in = (rec.status == SLOT_DONE) ? FSM_RESP : FSM_CUR_RD;
         end

         FSM_CUR_RD: begin
            ram_raddr = ci;
            state_in  = FSM_CUR_WR;
         end

         FSM_CUR_WR: begin
            unique case (action_ff)
               ACT_SLEEP: begin
                  if (dur_ff == '0) begin
                     upd.status = SLOT_READY;
                  end else begin
                     upd.status   = SLOT_SLEEP;
                     upd.deadline = sat_add(tick_ff, dur_ff);
                  end
               end
               ACT_WAIT: begin
                  upd.status   = SLOT_WAIT;
                  upd.key      = token_ff;
                  upd.expired  = 1'b0;
                  upd.deadline = (dur_ff == '0) ? TICK_MAX : sat_add(tick_ff, dur_ff);
               end
               ACT_JOIN: begin
                  upd.status  = SLOT_JOIN;
                  upd.join_on = tgt_ff;
               end
               ACT_FINISH: upd.status = SLOT_DONE;
               default:    upd.status = SLOT_READY;
            endcase
            ram_we    = 1'b1;
            ram_waddr = ci;
            ram_wdata = upd;
            cur_in    = '0;
            state_in  = FSM_RESP;
         end

         FSM_SIG_RD: state_in = FSM_SIG_EV;

         FSM_SIG_EV: begin
            state_in = FSM_SIG_RD;
            idx_in   = idx_p1[IW-1:0];
            if (rec.status == SLOT_WAIT && rec.key == token_ff) begin
               upd.status  = SLOT_READY;
               upd.expired = 1'b0;
               ram_we      = 1'b1;
               ram_wdata   = upd;
               woken_in    = woken_ff + CNT_ONE;
               if (!all_ff) begin
                  state_in = FSM_RESP;
               end
            end
            if (idx_last) begin
               state_in = FSM_RESP;
            end
         end

         // survey pass: which threads are finished
         FSM_DA_RD: state_in = FSM_DA_EV;

         FSM_DA_EV: begin
            done_mask_in[idx_ff] = (rec.status == SLOT_DONE);
            if (idx_last) begin
               if (every_done_ff && rec.status == SLOT_DONE) begin
                  res_status_in = RSP_ALL_DONE;
                  state_in      = FSM_RESP;
               end else begin
                  idx_in     = '0;
                  timed_in   = 1'b0;
                  blocked_in = 1'b0;
                  state_in   = FSM_DB_RD;
               end
            end else begin
               if (rec.status != SLOT_DONE) begin
                  every_done_in = 1'b0;
               end
               idx_in   = idx_p1[IW-1:0];
               state_in = FSM_DA_RD;
            end
         end

         // wake pass: unblock joiners, wake sleepers, expire waits
         FSM_DB_RD: state_in = FSM_DB_EV;

         FSM_DB_EV: begin
            if (rec.status == SLOT_JOIN && jt_free) begin
               upd.status = SLOT_READY;
            end else if (rec.status == SLOT_SLEEP && rec.deadline <= tick_ff) begin
               upd.status = SLOT_READY;
            end else if (rec.status == SLOT_WAIT && rec.deadline <= tick_ff) begin
               upd.status  = SLOT_READY;
               upd.expired = 1'b1;
            end
            ram_we    = 1'b1;
            ram_wdata = upd;
            ready_mask_in[idx_ff] = (upd.status == SLOT_READY);
            if (upd.status == SLOT_SLEEP ||
                (upd.status == SLOT_WAIT && upd.deadline != TICK_MAX)) begin
               timed_in = 1'b1;
            end
            if (upd.status == SLOT_JOIN ||
                (upd.status == SLOT_WAIT && upd.deadline == TICK_MAX)) begin
               blocked_in = 1'b1;
            end
            if (idx_last) begin
               idx_in   = rr_ff;
               k_in     = '0;
               state_in = FSM_PICK;
            end else begin
               idx_in   = idx_p1[IW-1:0];
               state_in = FSM_DB_RD;
            end
         end

         // round robin search from rr position
         FSM_PICK: begin
            if (ready_mask_ff[idx_ff]) begin
               state_in = FSM_SEL_RD;
            end else if (CNT_W'(k_ff) + CNT_ONE == created_ff) begin
               // nothing ready: advance time, deadlock or done
               state_in = FSM_RESP;
               if (timed_ff) begin
                  tick_in       = sat_add(tick_ff, TICK_W'(1));
                  res_status_in = RSP_TICK;
               end else if (blocked_ff) begin
                  res_status_in = RSP_DEADLOCK;
               end else begin
                  res_status_in = RSP_ALL_DONE;
               end
            end else begin
               k_in   = k_ff + IW'(1);
               idx_in = idx_last ? '0 : idx_p1[IW-1:0];
            end
         end

         FSM_SEL_RD: state_in = FSM_SEL_WR;

         FSM_SEL_WR: begin
            upd.status    = SLOT_RUNNING;
            upd.expired   = 1'b0;
            ram_we        = 1'b1;
            ram_wdata     = upd;
            res_timed_in  = rec.expired;
            res_handle_in = HANDLE_W'(idx_p1);
            cur_in        = idx_p1;
            rr_in         = idx_last ? '0 : idx_p1[IW-1:0];
            state_in      = FSM_RESP;
         end

         FSM_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = {5'b0, tick_ff, res_timed_ff,
                                HANDLE_W'(woken_ff), res_handle_ff};
               state_in      = FSM_IDLE;
            end
         end

         default: state_in = FSM_IDLE;
      endcase
   end

   `RRTS_ASSERT_NOW(a_cur_in_range, clock, reset, cur_ff != '0,
      cur_ff <= created_ff, "running thread beyond spawned threads")
   `RRTS_ASSERT_NOW(a_rr_in_range, clock, reset, created_ff != '0,
      CNT_W'(rr_ff) < created_ff, "round robin position out of range")
   `RRTS_ASSERT_NOW(a_created_cap, clock, reset, 1'b1,
      created_ff <= CNT_MAX, "thread count beyond table size")
   `RRTS_ASSERT_NEXT(a_resp_loads, clock, reset,
      state_ff == FSM_RESP && (!rsp_valid_ff || rsp_tready),
      rsp_valid_ff && state_ff == FSM_IDLE, "result not loaded into output")

endmodule

`default_nettype wire
